FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; sampled on clk_i, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/frmt_pkg.sv
`timescale 1ns / 1ps

package frmt_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned ProtoW = 8;

  localparam logic [ProtoW-1:0] ProtoTcp = 8'd6;
  localparam logic [ProtoW-1:0] ProtoUdp = 8'd17;

  typedef enum logic {
    ReqRecord = 1'b0,
    ReqMatch  = 1'b1
  } req_e;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [AddrW-1:0] orig;
  } token_t;

endpackage

FILE: hw/rtl/flow_reverse_match_table_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                      Payload
// request   start in, busy out             req_type_i protocol_i src_addr_i dst_addr_i
//                                          src_port_i dst_port_i
// result    result_valid_o (one cycle)     ok_o orig_addr_o
//
// A request with a protocol other than TCP or UDP answers in the next cycle.
// A match, or a record that fills a slot after the pointer, answers once the
// token has crossed the cell row; a record that wraps, or finds the table full,
// once the token has crossed it twice. The token crosses one cell a cycle.
// Reset clears the pointer and the port fields of every cell at once.
// The result is shown for one cycle and cannot be held off.

module flow_reverse_match_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [frmt_pkg::ProtoW-1:0] protocol_i,
  input  logic [frmt_pkg::AddrW-1:0]  src_addr_i,
  input  logic [frmt_pkg::AddrW-1:0]  dst_addr_i,
  input  logic [frmt_pkg::PortW-1:0]  src_port_i,
  input  logic [frmt_pkg::PortW-1:0]  dst_port_i,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic [frmt_pkg::AddrW-1:0]  orig_addr_o
);
  import frmt_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  logic             busy_q, pass_q;
  logic [IdxW-1:0]  ptr_q;
  req_e             req_q;
  logic             udp_q;
  logic [AddrW-1:0] sa_q, da_q;
  logic [PortW-1:0] sp_q, dp_q;
  logic             res_valid_q, ok_q;
  logic [AddrW-1:0] orig_q;

  token_t          tok_chain [TABLE_ENTRIES+1];
  logic [IdxW-1:0] idx_chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] tok_live;

  logic   accept, good, reinj, finish;
  token_t last_tok;

  assign accept   = start && !busy_q;
  assign good     = (protocol_i == ProtoTcp) || (protocol_i == ProtoUdp);
  assign last_tok = tok_chain[TABLE_ENTRIES];
  assign reinj    = last_tok.valid && !last_tok.done && (req_q == ReqRecord) && !pass_q;
  assign finish   = last_tok.valid && !reinj;

  // Inject a token at the head of the row, fresh or for the second pass
  assign tok_chain[0].valid = (accept && good) || reinj;
  assign tok_chain[0].done  = 1'b0;
  assign tok_chain[0].orig  = '0;
  assign idx_chain[0]       = '0;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_type_i);
      udp_q <= (protocol_i == ProtoUdp);
      sa_q  <= src_addr_i;
      da_q  <= dst_addr_i;
      sp_q  <= src_port_i;
      dp_q  <= dst_port_i;
    end
  end

  // Track busy, search pass and the next-fit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pass_q <= 1'b0;
      ptr_q  <= '0;
    end else begin
      if (accept) begin
        busy_q <= good;
        pass_q <= 1'b0;
      end else if (reinj) begin
        pass_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (accept && !good && (req_e'(req_type_i) == ReqRecord)) begin
        ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
      end else if (finish && last_tok.done && (req_q == ReqRecord)) begin
        ptr_q <= idx_chain[TABLE_ENTRIES];
      end
    end
  end

  // Drive the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (accept && !good) || finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      ok_q   <= last_tok.done;
      orig_q <= last_tok.orig;
    end else begin
      ok_q   <= 1'b0;
      orig_q <= '0;
    end
  end

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    frmt_cell #(
      .Index   (g),
      .IdxW    (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_chain[g]),
      .idx_i      (idx_chain[g]),
      .tok_o      (tok_chain[g+1]),
      .idx_o      (idx_chain[g+1]),
      .req_type_i (req_q),
      .is_udp_i   (udp_q),
      .src_addr_i (sa_q),
      .dst_addr_i (da_q),
      .src_port_i (sp_q),
      .dst_port_i (dp_q),
      .pass_i     (pass_q),
      .ptr_i      (ptr_q)
    );
    assign tok_live[g] = tok_chain[g+1].valid;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign ok_o           = ok_q;
  assign orig_addr_o    = orig_q;

  `ASSERT_IMPLY(a_single_token, 1'b1, $onehot0(tok_live))
  `ASSERT_NEXT(a_bad_proto_fails, accept && !good, result_valid_o && !ok_o && !busy)
  `ASSERT_IMPLY(a_record_no_addr, result_valid_o && (req_q == ReqRecord), orig_addr_o == '0)
  `ASSERT_IMPLY(a_token_only_busy, tok_live != '0, busy_q)

endmodule

FILE: hw/rtl/frmt_cell.sv
`timescale 1ns / 1ps

module frmt_cell #(
  parameter int unsigned Index   = 0,
  parameter int unsigned IdxW    = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frmt_pkg::token_t            tok_i,
  input  logic [IdxW-1:0]             idx_i,
  output frmt_pkg::token_t            tok_o,
  output logic [IdxW-1:0]             idx_o,
  input  frmt_pkg::req_e              req_type_i,
  input  logic                        is_udp_i,
  input  logic [frmt_pkg::AddrW-1:0]  src_addr_i,
  input  logic [frmt_pkg::AddrW-1:0]  dst_addr_i,
  input  logic [frmt_pkg::PortW-1:0]  src_port_i,
  input  logic [frmt_pkg::PortW-1:0]  dst_port_i,
  input  logic                        pass_i,
  input  logic [IdxW-1:0]             ptr_i
);
  import frmt_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic             tok_valid_q;
  logic             tok_done_q;
  logic [AddrW-1:0] tok_orig_q;
  logic [IdxW-1:0]  tok_idx_q;

  logic             ent_udp_q;
  logic [AddrW-1:0] ent_sa_q;
  logic [AddrW-1:0] ent_da_q;
  logic [PortW-1:0] ent_sp_q;
  logic [PortW-1:0] ent_dp_q;

  logic occupied, here, pos_ok, take_rec, hit;

  // Hold the token that arrived from the left neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_done_q <= tok_i.done;
    tok_orig_q <= tok_i.orig;
    tok_idx_q  <= idx_i;
  end

  // Decide whether this entry takes the request
  always_comb begin
    occupied = (ent_sp_q != '0) || (ent_dp_q != '0);
    here     = tok_valid_q && !tok_done_q;
    // first pass covers slots after the pointer, second pass the rest
    pos_ok   = pass_i ? (MyIdx <= ptr_i) : (MyIdx > ptr_i);
    take_rec = here && (req_type_i == ReqRecord) && !occupied && pos_ok;
    hit      = here && (req_type_i == ReqMatch) && occupied &&
               (ent_udp_q == is_udp_i) && (ent_sa_q == dst_addr_i) &&
               (is_udp_i || (ent_da_q == src_addr_i)) &&
               (ent_sp_q == dst_port_i) && (ent_dp_q == src_port_i);
  end

  // Advance the token to the right neighbor
  always_comb begin
    tok_o.valid = tok_valid_q;
    tok_o.done  = tok_done_q || take_rec || hit;
    tok_o.orig  = hit ? ent_da_q : tok_orig_q;
    idx_o       = take_rec ? MyIdx : tok_idx_q;
  end

  // Ports mark occupancy; clear them at reset and on a hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_sp_q <= '0;
      ent_dp_q <= '0;
    end else if (take_rec) begin
      ent_sp_q <= src_port_i;
      ent_dp_q <= dst_port_i;
    end else if (hit) begin
      ent_sp_q <= '0;
      ent_dp_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_rec) begin
      ent_udp_q <= is_udp_i;
      ent_sa_q  <= src_addr_i;
      ent_da_q  <= dst_addr_i;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import frmt_pkg::*;

  localparam int unsigned Slots = 64;

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] orig;
  } reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              req_type_i;
  logic [ProtoW-1:0] protocol_i;
  logic [AddrW-1:0]  src_addr_i;
  logic [AddrW-1:0]  dst_addr_i;
  logic [PortW-1:0]  src_port_i;
  logic [PortW-1:0]  dst_port_i;
  logic              result_valid_o;
  logic              ok_o;
  logic [AddrW-1:0]  orig_addr_o;

  // Mirror of the flow table, updated as each request is accepted
  bit               flow_is_udp   [Slots];
  logic [AddrW-1:0] flow_src_addr [Slots];
  logic [AddrW-1:0] flow_dst_addr [Slots];
  logic [PortW-1:0] flow_src_port [Slots];
  logic [PortW-1:0] flow_dst_port [Slots];
  int unsigned      last_slot;

  reply_t replies_due[$];
  reply_t want_reply;
  int     errors;
  int     idle_pct;
  int     n_requests;
  int     n_stored;
  int     n_hits;
  int     n_refused;

  flow_reverse_match_table_top #(
    .TABLE_ENTRIES(Slots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .protocol_i    (protocol_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .src_port_i    (src_port_i),
    .dst_port_i    (dst_port_i),
    .result_valid_o(result_valid_o),
    .ok_o          (ok_o),
    .orig_addr_o   (orig_addr_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d replies still outstanding", $time, replies_due.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit slot_taken(int unsigned s);
    return flow_src_port[s] != '0 || flow_dst_port[s] != '0;
  endfunction

  // Return the first occupied slot at or after from, or -1 when the table is empty
  function automatic int find_taken(int unsigned from);
    int unsigned s;
    for (int k = 0; k < Slots; k++) begin
      s = (from + k) % Slots;
      if (slot_taken(s)) return s;
    end
    return -1;
  endfunction

  // Compute the reply to one request and apply its effect on the table
  function automatic reply_t track_flow(req_e req, logic [ProtoW-1:0] proto,
                                        logic [AddrW-1:0] saddr, logic [AddrW-1:0] daddr,
                                        logic [PortW-1:0] sport, logic [PortW-1:0] dport);
    reply_t      r;
    bit          good;
    bit          udp;
    int unsigned s;
    r    = '0;
    good = (proto == ProtoTcp) || (proto == ProtoUdp);
    udp  = (proto == ProtoUdp);
    if (req == ReqRecord) begin
      if (!good) begin
        last_slot = (last_slot + 1) % Slots;
      end else begin
        // Next fit: scan after the pointer, pointer's own slot last
        s = last_slot;
        for (int k = 0; k < Slots; k++) begin
          s = (s + 1) % Slots;
          if (!slot_taken(s)) begin
            flow_is_udp[s]   = udp;
            flow_src_addr[s] = saddr;
            flow_dst_addr[s] = daddr;
            flow_src_port[s] = sport;
            flow_dst_port[s] = dport;
            last_slot        = s;
            r.ok             = 1'b1;
            break;
          end
        end
      end
    end else if (good) begin
      // Lowest matching index wins; UDP ignores the peer address
      for (int unsigned i = 0; i < Slots; i++) begin
        if (slot_taken(i) && flow_is_udp[i] == udp && flow_src_addr[i] == daddr &&
            (udp || flow_dst_addr[i] == saddr) &&
            flow_src_port[i] == dport && flow_dst_port[i] == sport) begin
          flow_src_port[i] = '0;
          flow_dst_port[i] = '0;
          r.orig           = flow_dst_addr[i];
          r.ok             = 1'b1;
          break;
        end
      end
    end
    if (!r.ok) n_refused++;
    else if (req == ReqRecord) n_stored++;
    else n_hits++;
    return r;
  endfunction

  function automatic int pick_gap();
    int gap;
    gap = 0;
    if (idle_pct == 0) return 0;
    // Now and then hold off long enough to land anywhere in a slow search
    if ($urandom_range(7) == 0) return $urandom_range(2 * Slots + 4);
    while ($urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  // Present one request, wait for it to be taken, then log its reply
  task automatic send_request(req_e req, logic [ProtoW-1:0] proto,
                              logic [AddrW-1:0] saddr, logic [AddrW-1:0] daddr,
                              logic [PortW-1:0] sport, logic [PortW-1:0] dport);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    protocol_i <= proto;
    src_addr_i <= saddr;
    dst_addr_i <= daddr;
    src_port_i <= sport;
    dst_port_i <= dport;
    do @(posedge clk_i); while (busy);
    n_requests++;
    replies_due.push_back(track_flow(req, proto, saddr, daddr, sport, dport));
  endtask

  function automatic logic [PortW-1:0] rand_port(bit allow_zero);
    if (allow_zero && $urandom_range(15) == 0) return '0;
    return PortW'($urandom_range(65535, 1));
  endfunction

  task automatic record_random(bit allow_zero);
    send_request(ReqRecord, $urandom_range(1) ? ProtoUdp : ProtoTcp, $urandom, $urandom,
                 rand_port(allow_zero), rand_port(allow_zero));
  endtask

  // Send the returning packet for the flow held in slot s
  task automatic answer_slot(int unsigned s);
    logic [AddrW-1:0] peer;
    peer = flow_dst_addr[s];
    if (flow_is_udp[s] && $urandom_range(1)) peer = $urandom;
    send_request(ReqMatch, flow_is_udp[s] ? ProtoUdp : ProtoTcp, peer, flow_src_addr[s],
                 flow_dst_port[s], flow_src_port[s]);
  endtask

  // Compare each reply against the oldest one logged
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply ok=%0b orig=%h", $time, ok_o, orig_addr_o);
        errors++;
      end else begin
        want_reply = replies_due.pop_front();
        if (ok_o !== want_reply.ok) begin
          $display("%0t: ok mismatch, expected %0b actual %0b", $time, want_reply.ok, ok_o);
          errors++;
        end
        if (orig_addr_o !== want_reply.orig) begin
          $display("%0t: orig_addr mismatch, expected %h actual %h",
                   $time, want_reply.orig, orig_addr_o);
          errors++;
        end
      end
    end
  end

  // Protocols other than TCP and UDP: all four requests refused
  task automatic test_bad_protocol();
    send_request(ReqRecord, 8'h00, 32'h0A00_0001, 32'h0A00_0002, 16'd1000, 16'd80);
    send_request(ReqRecord, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(ReqMatch, 8'h80, 32'h0, 32'h0, 16'h0, 16'h0);
    send_request(ReqMatch, 8'h07, 32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd1000);
  endtask

  // Plain TCP and UDP flows, repeats, wrong peer and wrong protocol
  task automatic test_basic_flows();
    send_request(ReqRecord, ProtoTcp, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    send_request(ReqRecord, ProtoUdp, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0001, 16'h8000);
    send_request(ReqRecord, ProtoTcp, 32'hC0A8_0001, 32'h0808_0808, 16'd5555, 16'd443);
    send_request(ReqRecord, ProtoTcp, 32'hC0A8_0001, 32'h0808_0808, 16'd5555, 16'd443);
    send_request(ReqRecord, ProtoUdp, 32'h0A00_0005, 32'h0101_0101, 16'h0000, 16'd53);
    send_request(ReqMatch, ProtoTcp, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(ReqMatch, ProtoTcp, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(ReqMatch, ProtoUdp, 32'h1234_5678, 32'h0000_0000, 16'h8000, 16'h0001);
    send_request(ReqMatch, ProtoTcp, 32'h0808_0809, 32'hC0A8_0001, 16'd443, 16'd5555);
    send_request(ReqMatch, ProtoTcp, 32'h0808_0808, 32'hC0A8_0001, 16'd443, 16'd5555);
    send_request(ReqMatch, ProtoTcp, 32'h0808_0808, 32'hC0A8_0001, 16'd443, 16'd5555);
    send_request(ReqMatch, ProtoTcp, 32'h0101_0101, 32'h0A00_0005, 16'd53, 16'h0000);
    send_request(ReqMatch, ProtoUdp, 32'h0101_0101, 32'h0A00_0005, 16'd53, 16'h0000);
  endtask

  // A record with both ports zero is stored but stays free
  task automatic test_zero_ports();
    send_request(ReqRecord, ProtoUdp, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'h0, 16'h0);
    send_request(ReqMatch, ProtoUdp, 32'h0B0B_0B0B, 32'h0A0A_0A0A, 16'h0, 16'h0);
    send_request(ReqRecord, ProtoTcp, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd7, 16'd9);
    send_request(ReqMatch, ProtoTcp, 32'h0B0B_0B0B, 32'h0A0A_0A0A, 16'd9, 16'd7);
  endtask

  // Fill the table, refuse when full, reuse the pointer's own slot, then drain
  task automatic test_table_full();
    while (find_taken(0) < 0 || !($countones({slot_taken_vec()}) == Slots)) record_random(0);
    record_random(0);
    send_request(ReqRecord, 8'h2F, $urandom, $urandom, rand_port(0), rand_port(0));
    record_random(0);
    answer_slot(last_slot);
    record_random(0);
    record_random(0);
    for (int unsigned s = 0; s < Slots; s++) begin
      if (slot_taken(s)) answer_slot(s);
    end
  endtask

  function automatic logic [Slots-1:0] slot_taken_vec();
    logic [Slots-1:0] v;
    for (int unsigned s = 0; s < Slots; s++) v[s] = slot_taken(s);
    return v;
  endfunction

  // Mostly well-formed record and answer traffic, with some noise
  task automatic test_random_traffic(int count, int pct);
    int unsigned pick;
    int          hit;
    logic [AddrW-1:0] keep_src;
    logic [AddrW-1:0] keep_dst;
    logic [PortW-1:0] keep_sport;
    logic [PortW-1:0] keep_dport;
    logic [ProtoW-1:0] keep_proto;
    idle_pct   = pct;
    keep_proto = ProtoTcp;
    keep_src   = $urandom;
    keep_dst   = $urandom;
    keep_sport = rand_port(0);
    keep_dport = rand_port(0);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Repeat a flow so that several entries can hold it
        send_request(ReqRecord, keep_proto, keep_src, keep_dst, keep_sport, keep_dport);
      end else if (pick < 42) begin
        keep_proto = $urandom_range(1) ? ProtoUdp : ProtoTcp;
        keep_src   = $urandom;
        keep_dst   = $urandom;
        keep_sport = rand_port(1);
        keep_dport = rand_port(1);
        send_request(ReqRecord, keep_proto, keep_src, keep_dst, keep_sport, keep_dport);
      end else if (pick < 82) begin
        hit = find_taken($urandom_range(Slots - 1));
        if (hit >= 0) answer_slot(hit);
        else send_request(ReqMatch, ProtoTcp, $urandom, $urandom, rand_port(1), rand_port(1));
      end else if (pick < 90) begin
        send_request(ReqMatch, $urandom_range(1) ? ProtoUdp : ProtoTcp, $urandom, $urandom,
                     rand_port(1), rand_port(1));
      end else begin
        send_request(req_e'($urandom_range(1)), ProtoW'($urandom_range(255)), $urandom,
                     $urandom, PortW'($urandom_range(65535)), PortW'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = ReqRecord;
    protocol_i  = '0;
    src_addr_i  = '0;
    dst_addr_i  = '0;
    src_port_i  = '0;
    dst_port_i  = '0;
    errors      = 0;
    idle_pct    = 0;
    n_requests  = 0;
    n_stored    = 0;
    n_hits      = 0;
    n_refused   = 0;
    last_slot   = 0;
    for (int unsigned s = 0; s < Slots; s++) begin
      flow_is_udp[s]   = 1'b0;
      flow_src_addr[s] = '0;
      flow_dst_addr[s] = '0;
      flow_src_port[s] = '0;
      flow_dst_port[s] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_protocol();
    test_basic_flows();
    test_zero_ports();
    test_table_full();
    test_random_traffic(232, 26);
    test_random_traffic(232, 83);
    test_random_traffic(232, 0);
    start <= 1'b0;

    // Drain outstanding replies, then watch for strays
    wait_cycles = 0;
    while (replies_due.size() != 0 && wait_cycles < 8 * Slots) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * Slots + 8) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, replies_due.size());
      errors++;
    end

    $display("Sent %0d requests: %0d flows stored, %0d returning packets matched,",
             n_requests, n_stored, n_hits);
    $display("%0d refused (full table, miss or bad protocol); %0d mismatches.",
             n_refused, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/frmt_pkg.sv
hw/rtl/frmt_cell.sv
hw/rtl/flow_reverse_match_table_top.sv
tb/sv/testbench.sv
